// File: rtl/mexp_pkg.sv
// Shared constants, types and command/status structs of the modular exponentiation block.
package mexp_pkg;

   localparam int WORD_BITS      = 64;
   localparam int FIELD_BITS     = 64;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CNT_BITS       = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [WORD_BITS+1:0]  wide_type;
   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_EXPONENT = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_MODULUS  = CSR_INDEX_BITS'(1);

   localparam cnt_type CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   typedef enum logic [2:0] {
      MODE_RED = 3'b001,
      MODE_ACC = 3'b010,
      MODE_SQR = 3'b100
   } mul_mode_type;

   typedef enum logic [2:0] {
      RES_ACC = 3'b001,
      RES_ONE = 3'b010,
      RES_ERR = 3'b100
   } res_sel_type;

   typedef struct packed {
      logic         load;
      logic         mul_start;
      mul_mode_type mul_mode;
      logic         mul_step;
      logic         wr_acc;
      logic         wr_base;
      logic         exp_shift;
      logic         capture;
      res_sel_type  res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic key_mod_zero;
      logic key_exp_zero;
      logic exp_lsb;
      logic exp_rest_zero;
   } dp_status_type;

endpackage

// File: rtl/mexp_if.sv
// Handshake channel interfaces: request, response and register write.
interface mexp_req_if;
   logic                 valid;
   logic                 ready;
   mexp_pkg::field_type  message;

   modport source (output valid, output message, input ready);
   modport sink   (input valid, input message, output ready);
endinterface

interface mexp_rsp_if;
   logic                 valid;
   logic                 ready;
   mexp_pkg::field_type  power_result;
   logic                 modulus_error;

   modport source (output valid, output power_result, output modulus_error, input ready);
   modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

interface mexp_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [mexp_pkg::CSR_INDEX_BITS-1:0]   index;
   mexp_pkg::field_type                   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/modular_exponentiation.sv
// Request accept to response valid: with a zero modulus or zero exponent the controller goes
// straight to ST_FIN; otherwise it reduces the message, then runs one square per exponent bit
// below the top set bit and one multiply per set bit before ST_FIN loads the response.
// One request at a time; the next is taken the cycle after the response is loaded,
// and a response still waiting in the output register holds the controller in its last state.
// Reset clears both key registers to zero and drops any request in flight.
module modular_exponentiation (
   input  logic        clock,
   input  logic        reset,
   mexp_req_if.sink    req_ch,
   mexp_rsp_if.source  rsp_ch,
   mexp_csr_if.sink    csr_ch
);

   mexp_pkg::dp_cmd_type    cmd;
   mexp_pkg::dp_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;
   mexp_pkg::field_type     power_result;
   logic                    modulus_error;

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ch),
      .req_message   (req_ch.message),
      .cmd           (cmd),
      .status        (status),
      .power_result  (power_result),
      .modulus_error (modulus_error)
   );

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.power_result  = power_result;
   assign rsp_ch.modulus_error = modulus_error;

endmodule

// File: rtl/mexp_datapath.sv
// Datapath: key registers, exponent shifter, operands and the shift-add modular multiplier.
module mexp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   mexp_csr_if.sink                csr,
   input  mexp_pkg::field_type     req_message,
   input  mexp_pkg::dp_cmd_type    cmd,
   output mexp_pkg::dp_status_type status,
   output mexp_pkg::field_type     power_result,
   output logic                    modulus_error
);

   mexp_pkg::word_type key_exp_ff, key_exp_in;
   mexp_pkg::word_type key_mod_ff, key_mod_in;
   mexp_pkg::word_type exp_ff, exp_in;
   mexp_pkg::word_type acc_ff, acc_in;
   mexp_pkg::word_type base_ff, base_in;
   mexp_pkg::word_type prod_ff, prod_in;
   mexp_pkg::word_type mula_ff, mula_in;
   mexp_pkg::word_type mulb_ff, mulb_in;
   mexp_pkg::word_type res_ff, res_in;
   logic               err_ff, err_in;

   mexp_pkg::word_type one_mod;
   mexp_pkg::wide_type dbl_sum;
   mexp_pkg::wide_type mod_one_x;
   mexp_pkg::wide_type mod_two_x;
   mexp_pkg::word_type step_out;

   assign csr.ready = 1'b1;

   // 1 mod n: zero only for a modulus of one
   assign one_mod = mexp_pkg::word_type'(key_mod_ff != mexp_pkg::word_type'(1));

   // One multiplier step: prod = 2*prod + bit*a, bit being the top bit of b, reduced by subtracting 2n or n
   always_comb begin
      mod_one_x = mexp_pkg::wide_type'(key_mod_ff);
      mod_two_x = mexp_pkg::wide_type'({key_mod_ff, 1'b0});
      dbl_sum   = mexp_pkg::wide_type'({prod_ff, 1'b0})
                + (mulb_ff[mexp_pkg::WORD_BITS-1] ? mexp_pkg::wide_type'(mula_ff) : '0);
      if (dbl_sum >= mod_two_x) begin
         step_out = mexp_pkg::word_type'(dbl_sum - mod_two_x);
      end else if (dbl_sum >= mod_one_x) begin
         step_out = mexp_pkg::word_type'(dbl_sum - mod_one_x);
      end else begin
         step_out = mexp_pkg::word_type'(dbl_sum);
      end
   end

   always_comb begin
      key_exp_in = key_exp_ff;
      key_mod_in = key_mod_ff;
      exp_in     = exp_ff;
      acc_in     = acc_ff;
      base_in    = base_ff;
      prod_in    = prod_ff;
      mula_in    = mula_ff;
      mulb_in    = mulb_ff;
      res_in     = res_ff;
      err_in     = err_ff;

      if (csr.valid && csr.ready) begin
         case (csr.index)
            mexp_pkg::REG_KEY_EXPONENT: key_exp_in = mexp_pkg::word_type'(csr.data);
            mexp_pkg::REG_KEY_MODULUS:  key_mod_in = mexp_pkg::word_type'(csr.data);
            default: ;
         endcase
      end

      // Load starts the reduction of the message: (1 mod n) * message
      if (cmd.load) begin
         exp_in  = key_exp_ff;
         acc_in  = one_mod;
         prod_in = '0;
         mula_in = one_mod;
         mulb_in = mexp_pkg::word_type'(req_message);
      end

      if (cmd.mul_start) begin
         prod_in = '0;
         mula_in = (cmd.mul_mode == mexp_pkg::MODE_ACC) ? acc_ff : base_ff;
         mulb_in = base_ff;
      end

      if (cmd.mul_step) begin
         prod_in = step_out;
         mulb_in = mulb_ff << 1;
      end

      if (cmd.wr_base) begin
         base_in = step_out;
      end
      if (cmd.wr_acc) begin
         acc_in = step_out;
      end
      if (cmd.exp_shift) begin
         exp_in = exp_ff >> 1;
      end

      if (cmd.capture) begin
         case (cmd.res_sel)
            mexp_pkg::RES_ERR: begin
               res_in = '0;
               err_in = 1'b1;
            end
            mexp_pkg::RES_ONE: begin
               res_in = mexp_pkg::word_type'(1);
               err_in = 1'b0;
            end
            default: begin
               res_in = acc_ff;
               err_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_exp_ff <= '0;
         key_mod_ff <= '0;
      end else begin
         key_exp_ff <= key_exp_in;
         key_mod_ff <= key_mod_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      mula_ff <= mula_in;
      mulb_ff <= mulb_in;
      res_ff  <= res_in;
      err_ff  <= err_in;
   end

   assign status.key_mod_zero  = (key_mod_ff == '0);
   assign status.key_exp_zero  = (key_exp_ff == '0);
   assign status.exp_lsb       = exp_ff[0];
   assign status.exp_rest_zero = ((exp_ff >> 1) == '0);

   assign power_result  = mexp_pkg::field_type'(res_ff);
   assign modulus_error = err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && cmd.res_sel == mexp_pkg::RES_ERR) |=> (err_ff && res_ff == '0))
      else $error("zero modulus response must be 0 with error set");

   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && cmd.res_sel == mexp_pkg::RES_ACC) |=> (res_ff < $past(key_mod_ff)))
      else $error("computed power not reduced below modulus");

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences reduction, square and multiply steps and the response handshake.
module mexp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mexp_pkg::dp_status_type status,
   output mexp_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_SETUP = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   mexp_pkg::cnt_type      cnt_ff, cnt_in;
   mexp_pkg::mul_mode_type mode_ff, mode_in;
   mexp_pkg::res_sel_type  sel_ff, sel_in;
   logic                   mulled_ff, mulled_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      sel_in       = sel_ff;
      mulled_in    = mulled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_mode = mode_ff;
      cmd.res_sel  = sel_ff;
      req_ready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               cnt_in    = mexp_pkg::CNT_LAST;
               mode_in   = mexp_pkg::MODE_RED;
               mulled_in = 1'b0;
               if (status.key_mod_zero) begin
                  sel_in   = mexp_pkg::RES_ERR;
                  state_in = ST_FIN;
               end else if (status.key_exp_zero) begin
                  sel_in   = mexp_pkg::RES_ONE;
                  state_in = ST_FIN;
               end else begin
                  sel_in   = mexp_pkg::RES_ACC;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SETUP;
               case (mode_ff)
                  mexp_pkg::MODE_ACC: begin
                     cmd.wr_acc = 1'b1;
                     mulled_in  = 1'b1;
                  end
                  mexp_pkg::MODE_SQR: begin
                     cmd.wr_base   = 1'b1;
                     cmd.exp_shift = 1'b1;
                     mulled_in     = 1'b0;
                  end
                  default: begin
                     cmd.wr_base = 1'b1;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            // multiply for the current exponent bit first, then square; drop trailing squares
            if (status.exp_lsb && !mulled_ff) begin
               cmd.mul_start = 1'b1;
               cmd.mul_mode  = mexp_pkg::MODE_ACC;
               mode_in       = mexp_pkg::MODE_ACC;
               cnt_in        = mexp_pkg::CNT_LAST;
               state_in      = ST_MUL;
            end else if (status.exp_rest_zero) begin
               state_in = ST_FIN;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_mode  = mexp_pkg::MODE_SQR;
               mode_in       = mexp_pkg::MODE_SQR;
               cnt_in        = mexp_pkg::CNT_LAST;
               state_in      = ST_MUL;
            end
         end
         ST_FIN: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mulled_ff    <= 1'b0;
         cnt_ff       <= '0;
         mode_ff      <= mexp_pkg::MODE_RED;
         sel_ff       <= mexp_pkg::RES_ACC;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mulled_ff    <= mulled_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         sel_ff       <= sel_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_mul_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && cnt_ff == '0) |=> (state_ff == ST_SETUP))
      else $error("multiply did not end after the last step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start work");

endmodule

// File: test/modular_exponentiation_tb.sv
// Self-checking testbench for the modular exponentiation block: key writes, messages, checks.
module modular_exponentiation_tb;

   localparam int STALL_LIMIT  = 60000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 80;

   typedef enum logic [1:0] {
      CMD_MESSAGE,
      CMD_KEY_WRITE,
      CMD_IDLE_MIX
   } cmd_kind_type;

   typedef struct {
      cmd_kind_type                        kind;
      logic [mexp_pkg::CSR_INDEX_BITS-1:0] index;
      mexp_pkg::field_type                 value;
      int unsigned                         snd_pct;
      int unsigned                         rcv_pct;
   } pending_cmd_type;

   typedef struct packed {
      mexp_pkg::field_type power_result;
      logic                modulus_error;
   } power_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mexp_req_if req_ch();
   mexp_rsp_if rsp_ch();
   mexp_csr_if csr_ch();

   modular_exponentiation u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pending_cmd_type    pending_cmds[$];
   power_reply_type    expected_powers[$];
   mexp_pkg::word_type exponent_copy = '0;
   mexp_pkg::word_type modulus_copy  = '0;
   int unsigned        snd_idle_pct  = 0;
   int unsigned        rcv_idle_pct  = 0;
   int                 error_count   = 0;
   int                 stall_cycles  = 0;
   logic               launch_req;
   logic               launch_csr;
   power_reply_type    oldest_power;

   function automatic power_reply_type predict_power(mexp_pkg::field_type message);
      power_reply_type                  reply;
      logic [2*mexp_pkg::WORD_BITS-1:0] base;
      logic [2*mexp_pkg::WORD_BITS-1:0] acc;
      reply.power_result  = '0;
      reply.modulus_error = 1'b0;
      if (modulus_copy == '0) begin
         reply.modulus_error = 1'b1;
      end else if (exponent_copy == '0) begin
         reply.power_result = mexp_pkg::field_type'(1);
      end else begin
         base = mexp_pkg::word_type'(message) % modulus_copy;
         acc  = 1 % modulus_copy;
         for (int i = 0; i < mexp_pkg::WORD_BITS; i++) begin
            if (exponent_copy[i]) acc = (acc * base) % modulus_copy;
            base = (base * base) % modulus_copy;
         end
         reply.power_result = mexp_pkg::field_type'(acc[mexp_pkg::WORD_BITS-1:0]);
      end
      return reply;
   endfunction

   function automatic mexp_pkg::field_type rand_word();
      return {$urandom, $urandom};
   endfunction

   // random value no wider than nbits
   function automatic mexp_pkg::field_type rand_bits(int nbits);
      return rand_word() >> (mexp_pkg::FIELD_BITS - nbits);
   endfunction

   task automatic push_message(mexp_pkg::field_type value);
      pending_cmd_type cmd;
      cmd.kind  = CMD_MESSAGE;
      cmd.value = value;
      pending_cmds.push_back(cmd);
   endtask

   task automatic push_key(logic [mexp_pkg::CSR_INDEX_BITS-1:0] index,
                           mexp_pkg::field_type value);
      pending_cmd_type cmd;
      cmd.kind  = CMD_KEY_WRITE;
      cmd.index = index;
      cmd.value = value;
      pending_cmds.push_back(cmd);
   endtask

   task automatic push_mix(int unsigned snd_pct, int unsigned rcv_pct);
      pending_cmd_type cmd;
      cmd.kind    = CMD_IDLE_MIX;
      cmd.snd_pct = snd_pct;
      cmd.rcv_pct = rcv_pct;
      pending_cmds.push_back(cmd);
   endtask

   // Driver: one request per channel in flight; key writes wait for an idle block.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_powers.push_back(predict_power(req_ch.message));
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               mexp_pkg::REG_KEY_EXPONENT: exponent_copy = mexp_pkg::word_type'(csr_ch.data);
               mexp_pkg::REG_KEY_MODULUS:  modulus_copy  = mexp_pkg::word_type'(csr_ch.data);
               default: ;
            endcase
         end
         if (!(req_ch.valid && !req_ch.ready) && !(csr_ch.valid && !csr_ch.ready)) begin
            launch_req = 1'b0;
            launch_csr = 1'b0;
            if (pending_cmds.size() != 0) begin
               case (pending_cmds[0].kind)
                  CMD_IDLE_MIX: begin
                     snd_idle_pct = pending_cmds[0].snd_pct;
                     rcv_idle_pct = pending_cmds[0].rcv_pct;
                     void'(pending_cmds.pop_front());
                  end
                  CMD_MESSAGE: begin
                     if ($urandom_range(99) >= snd_idle_pct) begin
                        req_ch.message <= pending_cmds[0].value;
                        launch_req = 1'b1;
                        void'(pending_cmds.pop_front());
                     end
                  end
                  CMD_KEY_WRITE: begin
                     // hold until every outstanding result is back
                     if (expected_powers.size() == 0) begin
                        csr_ch.index <= pending_cmds[0].index;
                        csr_ch.data  <= pending_cmds[0].value;
                        launch_csr = 1'b1;
                        void'(pending_cmds.pop_front());
                     end
                  end
                  default: ;
               endcase
            end
            req_ch.valid <= launch_req;
            csr_ch.valid <= launch_csr;
         end
      end
   end

   // Monitor: random back-pressure, compare each result with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_powers.size() == 0) begin
               $error("unexpected result: power_result %h modulus_error %b",
                      rsp_ch.power_result, rsp_ch.modulus_error);
               error_count++;
            end else begin
               oldest_power = expected_powers.pop_front();
               if (rsp_ch.power_result !== oldest_power.power_result) begin
                  $error("power_result: expected %h, actual %h",
                         oldest_power.power_result, rsp_ch.power_result);
                  error_count++;
               end
               if (rsp_ch.modulus_error !== oldest_power.modulus_error) begin
                  $error("modulus_error: expected %b, actual %b",
                         oldest_power.modulus_error, rsp_ch.modulus_error);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int                  random_sent;
      int                  mix_stage;
      int                  burst;
      mexp_pkg::field_type modulus;
      mexp_pkg::field_type exponent;
      mexp_pkg::field_type message;

      req_ch.valid   = 1'b0;
      req_ch.message = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      rsp_ch.ready   = 1'b0;

      push_mix(21, 52);
      // keys still at reset: zero modulus with zero exponent
      push_message('0);
      push_message('1);
      // zero modulus, nonzero exponent
      push_key(mexp_pkg::REG_KEY_EXPONENT, mexp_pkg::field_type'(5));
      push_message(mexp_pkg::field_type'(7));
      // zero exponent gives one, even for a modulus of one
      push_key(mexp_pkg::REG_KEY_MODULUS, mexp_pkg::field_type'(1));
      push_key(mexp_pkg::REG_KEY_EXPONENT, '0);
      push_message(mexp_pkg::field_type'(12345));
      push_message('0);
      // modulus of one with nonzero exponent
      push_key(mexp_pkg::REG_KEY_EXPONENT, mexp_pkg::field_type'(3));
      push_message('1);
      // small key pair: encrypt, then decrypt
      push_key(mexp_pkg::REG_KEY_MODULUS, mexp_pkg::field_type'(3233));
      push_key(mexp_pkg::REG_KEY_EXPONENT, mexp_pkg::field_type'(17));
      push_message(mexp_pkg::field_type'(65));
      push_message(mexp_pkg::field_type'(3233 + 65));
      push_message('0);
      push_message(mexp_pkg::field_type'(3232));
      push_key(mexp_pkg::REG_KEY_EXPONENT, mexp_pkg::field_type'(2753));
      push_message(mexp_pkg::field_type'(2790));
      // widest exponent and modulus
      push_key(mexp_pkg::REG_KEY_EXPONENT, '1);
      push_key(mexp_pkg::REG_KEY_MODULUS, '1);
      push_message('1);
      push_message(mexp_pkg::field_type'(2));
      push_message({1'b1, {(mexp_pkg::FIELD_BITS-1){1'b0}}});
      push_key(mexp_pkg::REG_KEY_EXPONENT, {1'b1, {(mexp_pkg::FIELD_BITS-1){1'b0}}});
      push_key(mexp_pkg::REG_KEY_MODULUS, {1'b1, {(mexp_pkg::FIELD_BITS-1){1'b0}}});
      push_message('1);
      push_message(mexp_pkg::field_type'(3));
      // writes to unused indexes must leave the keys alone
      push_key({mexp_pkg::CSR_INDEX_BITS{1'b1}}, '1);
      push_key(mexp_pkg::CSR_INDEX_BITS'(2), '0);
      push_message({(mexp_pkg::FIELD_BITS/2){2'b01}});
      push_key(mexp_pkg::REG_KEY_EXPONENT, '0);
      push_key(mexp_pkg::REG_KEY_MODULUS, '1);
      push_message({(mexp_pkg::FIELD_BITS/2){2'b10}});

      random_sent = 0;
      mix_stage   = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (mix_stage == 0 && random_sent >= RANDOM_ITEMS / 3) begin
            push_mix(52, 21);
            mix_stage = 1;
         end else if (mix_stage == 1 && random_sent >= 2 * RANDOM_ITEMS / 3) begin
            push_mix(0, 0);
            mix_stage = 2;
         end
         case ($urandom_range(9))
            0:       modulus = '0;
            1:       modulus = mexp_pkg::field_type'(1);
            2:       modulus = '1;
            default: modulus = rand_bits($urandom_range(2, mexp_pkg::FIELD_BITS));
         endcase
         // keep most exponents short: the run time grows with the top set bit
         case ($urandom_range(9))
            0:       exponent = '0;
            1:       exponent = rand_word();
            default: exponent = rand_bits($urandom_range(1, 12));
         endcase
         if ($urandom_range(1)) begin
            push_key(mexp_pkg::REG_KEY_MODULUS, modulus);
            push_key(mexp_pkg::REG_KEY_EXPONENT, exponent);
         end else begin
            push_key(mexp_pkg::REG_KEY_EXPONENT, exponent);
            push_key(mexp_pkg::REG_KEY_MODULUS, modulus);
         end
         if ($urandom_range(3) == 0)
            push_key(mexp_pkg::CSR_INDEX_BITS'($urandom_range(2, 255)), rand_word());
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst; k++) begin
            case ($urandom_range(3))
               0:       message = rand_word();
               1:       message = rand_bits($urandom_range(1, mexp_pkg::FIELD_BITS));
               2:       message = (modulus != '0) ? rand_word() % modulus : rand_word();
               default: message = $urandom_range(1) ? '1 : modulus;
            endcase
            push_message(message);
            random_sent++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_ch.valid || csr_ch.valid ||
             expected_powers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_powers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
